FILE: hw/rtl/vtfb_pkg.sv
package vtfb_pkg;

  // Frame geometry.
  localparam int FRAME_BYTES = 124;
  localparam int WORD_COUNT  = (FRAME_BYTES + 3) / 4;
  localparam int BUF_BYTES   = WORD_COUNT * 4;
  localparam int WORD_IDX_W  = $clog2(WORD_COUNT);
  localparam int BYTE_IDX_W  = WORD_IDX_W + 2;

  // Byte offsets of the variable parts of the frame.
  localparam int OFS_BLOB = 19;
  localparam int OFS_T1   = 54;
  localparam int OFS_T2   = 63;

  // Fixed header bytes.
  localparam logic [7:0] DEST_FIRST = 8'h03;
  localparam logic [7:0] TPID_HI    = 8'h81;
  localparam logic [7:0] TPID_LO    = 8'h00;
  localparam logic [7:0] ETYPE_HI   = 8'h88;
  localparam logic [7:0] ETYPE_LO   = 8'hF7;

  // Timestamp split: radix-8 division by one second in nanoseconds.
  localparam logic [29:0] NS_PER_SEC = 30'd1000000000;
  localparam int DIV_STEPS = 22;
  localparam int DVD_W     = 3 * DIV_STEPS;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  // One frame as it travels from the front to the back.
  typedef struct packed {
    logic [47:0] mac;
    logic [15:0] link;
    logic [11:0] vlan;
    logic [7:0]  mtype;
    logic [31:0] sec1;
    logic [29:0] ns1;
    logic [31:0] sec2;
    logic [29:0] ns2;
  } frame_rec_t;

  // A digit times one second, for the divider's compare and subtract.
  function automatic logic [32:0] ns_multiple(input logic [2:0] d);
    return 33'(NS_PER_SEC) * 33'(d);
  endfunction

  // The fixed data blob after the message type.
  function automatic logic [7:0] blob_byte(input logic [5:0] idx);
    logic [7:0] b;
    case (idx)
      6'd0:    b = 8'h02;
      6'd2:    b = 8'h6a;
      6'd3:    b = 8'h0b;
      6'd5:    b = 8'h01;
      6'd6:    b = 8'h02;
      6'd19:   b = 8'h6d;
      6'd20:   b = 8'h61;
      6'd21:   b = 8'h73;
      6'd22:   b = 8'h74;
      6'd23:   b = 8'h65;
      6'd24:   b = 8'h72;
      6'd25:   b = 8'h64;
      6'd26:   b = 8'h65;
      6'd27:   b = 8'h76;
      6'd28:   b = 8'h2e;
      6'd30:   b = 8'h02;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // One byte of the frame at a given position; padding reads as zero.
  function automatic logic [7:0] frame_byte(input frame_rec_t rec,
                                            input logic [BYTE_IDX_W-1:0] pos);
    logic [7:0]  b;
    logic [31:0] ns1_w;
    logic [31:0] ns2_w;
    int p;
    ns1_w = {2'b00, rec.ns1};
    ns2_w = {2'b00, rec.ns2};
    p = int'(pos);
    b = 8'h00;
    case (pos) inside
      0:        b = DEST_FIRST;
      [4:5]:    b = rec.link[8 * (5 - p) +: 8];
      [6:11]:   b = rec.mac[8 * (11 - p) +: 8];
      12:       b = TPID_HI;
      13:       b = TPID_LO;
      14:       b = {4'h0, rec.vlan[11:8]};
      15:       b = rec.vlan[7:0];
      16:       b = ETYPE_HI;
      17:       b = ETYPE_LO;
      18:       b = rec.mtype;
      [19:53]:  b = blob_byte(6'(p - OFS_BLOB));
      [54:57]:  b = rec.sec1[8 * (OFS_T1 + 3 - p) +: 8];
      [58:61]:  b = ns1_w[8 * (OFS_T1 + 7 - p) +: 8];
      [63:66]:  b = rec.sec2[8 * (OFS_T2 + 3 - p) +: 8];
      [67:70]:  b = ns2_w[8 * (OFS_T2 + 7 - p) +: 8];
      default:  b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

FILE: hw/rtl/vtfb_div.sv
module vtfb_div (
  input  logic                   clk,
  input  logic                   load,
  input  logic                   run,
  input  logic [63:0]            dividend,
  output logic [31:0]            quotient,
  output logic [29:0]            remainder
);
  import vtfb_pkg::*;

  logic [DVD_W-1:0] dvd;
  logic [32:0]      x;
  logic [2:0]       digit;
  logic [32:0]      diff;

  // One radix-8 step: bring down three bits, pick the largest fitting digit.
  always_comb begin
    x = {remainder, dvd[DVD_W-1 -: 3]};
    digit = 3'd0;
    for (int k = 1; k < 8; k++) begin
      if (x >= ns_multiple(3'(k))) begin
        digit = 3'(k);
      end
    end
    diff = x - ns_multiple(digit);
  end

  // Only the low 32 quotient bits are kept, so seconds wrap.
  always_ff @(posedge clk) begin
    if (load) begin
      dvd       <= {{(DVD_W - 64){1'b0}}, dividend};
      quotient  <= '0;
      remainder <= '0;
    end else if (run) begin
      dvd       <= {dvd[DVD_W-4:0], 3'b000};
      quotient  <= {quotient[28:0], digit};
      remainder <= diff[29:0];
    end
  end

endmodule

FILE: hw/rtl/vtfb_front.sv
module vtfb_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [11:0]          vlan_id,
  input  logic [15:0]          link_id,
  input  logic [47:0]          source_mac,
  input  logic [7:0]           message_type,
  input  logic [63:0]          first_time_ns,
  input  logic [63:0]          second_time_ns,
  output logic                 q_push,
  input  logic                 q_full,
  output vtfb_pkg::frame_rec_t q_data
);
  import vtfb_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]        state;
  logic [1:0]        state_next;
  logic [STEP_W-1:0] step_cnt;
  logic              accept;
  logic              run;
  logic [47:0]       mac;
  logic [15:0]       link;
  logic [11:0]       vlan;
  logic [7:0]        mtype;
  logic [31:0]       sec1;
  logic [29:0]       ns1;
  logic [31:0]       sec2;
  logic [29:0]       ns2;

  // Handshake: a finished frame leaves in the same cycle the next beat enters.
  assign in_stall = (state == ST_DIV) || (state == ST_DONE && q_full);
  assign accept   = in_valid && !in_stall;
  assign q_push   = (state == ST_DONE) && !q_full;
  assign run      = (state == ST_DIV);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept) state_next = ST_DIV;
      ST_DIV:  if (step_cnt == STEP_W'(DIV_STEPS - 1)) state_next = ST_DONE;
      ST_DONE: begin
        if (accept) begin
          state_next = ST_DIV;
        end else if (q_push) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      step_cnt <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        step_cnt <= '0;
      end else if (run) begin
        step_cnt <= step_cnt + 1'b1;
      end
    end
  end

  // Header fields held for the frame under division.
  always_ff @(posedge clk) begin
    if (accept) begin
      mac   <= source_mac;
      link  <= link_id;
      vlan  <= vlan_id;
      mtype <= message_type;
    end
  end

  // Both timestamps are split side by side.
  vtfb_div u_div1 (
    .clk       (clk),
    .load      (accept),
    .run       (run),
    .dividend  (first_time_ns),
    .quotient  (sec1),
    .remainder (ns1)
  );

  vtfb_div u_div2 (
    .clk       (clk),
    .load      (accept),
    .run       (run),
    .dividend  (second_time_ns),
    .quotient  (sec2),
    .remainder (ns2)
  );

  always_comb begin
    q_data.mac   = mac;
    q_data.link  = link;
    q_data.vlan  = vlan;
    q_data.mtype = mtype;
    q_data.sec1  = sec1;
    q_data.ns1   = ns1;
    q_data.sec2  = sec2;
    q_data.ns2   = ns2;
  end

`ifndef SYNTH
  // A finished split always leaves a remainder below one second.
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |-> (ns1 < NS_PER_SEC && ns2 < NS_PER_SEC))
    else $error("divider remainder out of range");
`endif

endmodule

FILE: hw/rtl/vtfb_queue.sv
module vtfb_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  vtfb_pkg::frame_rec_t push_data,
  output logic                 full,
  input  logic                 pop,
  output logic                 not_empty,
  output vtfb_pkg::frame_rec_t pop_data
);
  import vtfb_pkg::*;

  frame_rec_t  entry [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign pop_data  = entry[rd_ptr];

  // Two-entry ring of frame records between front and back.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

`ifndef SYNTH
  // The front must never write into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("queue written while full");

  // The back must never read an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("queue read while empty");
`endif

endmodule

FILE: hw/rtl/vtfb_back.sv
module vtfb_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  output logic                 q_pop,
  input  vtfb_pkg::frame_rec_t q_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [31:0]          frame_word,
  output logic                 last_word
);
  import vtfb_pkg::*;

  frame_rec_t            rec;
  logic                  active;
  logic [WORD_IDX_W-1:0] idx;
  logic                  adv;
  logic                  at_last;
  logic [31:0]           word;

  assign adv     = !out_valid || !out_stall;
  assign at_last = (idx == WORD_IDX_W'(WORD_COUNT - 1));
  // The next frame is loaded as the current one sends its last beat.
  assign q_pop   = q_valid && (!active || (adv && at_last));

  // Assemble the word at the current index, earliest byte on top.
  always_comb begin
    for (int b = 0; b < 4; b++) begin
      word[31 - 8 * b -: 8] = frame_byte(rec, {idx, 2'(b)});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (adv) begin
        if (active) begin
          out_valid <= 1'b1;
          idx       <= idx + 1'b1;
          if (at_last) active <= 1'b0;
        end else begin
          out_valid <= 1'b0;
        end
      end
      if (q_pop) begin
        active <= 1'b1;
        idx    <= '0;
      end
    end
  end

  // Output register and the record being sent.
  always_ff @(posedge clk) begin
    if (adv && active) begin
      frame_word <= word;
      last_word  <= at_last;
    end
    if (q_pop) begin
      rec <= q_data;
    end
  end

`ifndef SYNTH
  // The word index stays inside the frame while a frame is being sent.
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    active |-> (idx <= WORD_IDX_W'(WORD_COUNT - 1)))
    else $error("word index beyond frame");
`endif

endmodule

FILE: hw/rtl/vlan_timesync_frame_builder_top.sv
// The back sends a frame of 31 words, one word a cycle while out_stall is low;
// the front's radix-8 divider pair holds in_stall while dividing and runs ahead.
// A two-entry queue between front and back lets either side stall alone.
// Reset (rst, synchronous) empties the queue and drops any frame in flight.
module vlan_timesync_frame_builder_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [11:0] vlan_id,
  input  logic [15:0] link_id,
  input  logic [47:0] source_mac,
  input  logic [7:0]  message_type,
  input  logic [63:0] first_time_ns,
  input  logic [63:0] second_time_ns,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] frame_word,
  output logic        last_word
);
  import vtfb_pkg::*;

  frame_rec_t push_data;
  frame_rec_t pop_data;
  logic       push;
  logic       full;
  logic       pop;
  logic       not_empty;

  vtfb_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .vlan_id        (vlan_id),
    .link_id        (link_id),
    .source_mac     (source_mac),
    .message_type   (message_type),
    .first_time_ns  (first_time_ns),
    .second_time_ns (second_time_ns),
    .q_push         (push),
    .q_full         (full),
    .q_data         (push_data)
  );

  vtfb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .pop_data  (pop_data)
  );

  vtfb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (not_empty),
    .q_pop      (pop),
    .q_data     (pop_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .frame_word (frame_word),
    .last_word  (last_word)
  );

endmodule

FILE: tb/tb_vlan_timesync_frame_builder_top.sv
`timescale 1ns / 100ps

module tb_vlan_timesync_frame_builder_top;
  import vtfb_pkg::*;

  localparam int CYCLE_LIMIT = 6000000;
  localparam int DRAIN_WAIT = 60;
  localparam int LONG_HOLD = 400;
  localparam int HOLD_AFTER_BEATS = 30;
  localparam int RANDOM_ITEMS = 450;
  localparam int OFS_MSG = 18;
  localparam int BLOB_LEN = 35;
  localparam logic [63:0] ONE_SEC = 64'd1000000000;
  localparam logic [63:0] WRAP_NS = 64'd4294967296000000000;

  // Message type codes.
  localparam logic [7:0] MSG_SYNC     = 8'd0;
  localparam logic [7:0] MSG_REQUEST  = 8'd1;
  localparam logic [7:0] MSG_RESPONSE = 8'd9;

  // The fixed 35-byte blob, first byte in the top bits.
  localparam logic [8*BLOB_LEN-1:0] BLOB_PATTERN =
    280'h02006a0b_00010200_00000000_00000000_0000006d_61737465_72646576_2e000200_000000;

  // One frame request plus how the sender presents it.
  typedef struct {
    logic [11:0] vlan;
    logic [15:0] link;
    logic [47:0] mac;
    logic [7:0]  mtype;
    logic [63:0] t1;
    logic [63:0] t2;
    int          gap;
    bit          drain_first;
  } frame_desc_t;

  typedef struct {
    logic [31:0] word;
    logic        last;
  } frame_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [11:0] vlan_id = '0;
  logic [15:0] link_id = '0;
  logic [47:0] source_mac = '0;
  logic [7:0]  message_type = '0;
  logic [63:0] first_time_ns = '0;
  logic [63:0] second_time_ns = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] frame_word;
  logic        last_word;

  frame_desc_t pending_frames[$];
  frame_beat_t frame_words_due[$];
  frame_desc_t next_frame;
  frame_desc_t taken_frame;
  frame_beat_t want_beat;

  int cycle_count = 0;
  int mismatches = 0;
  int beats_in = 0;
  int offered = 0;
  int words_seen = 0;

  int  hold_left = 0;
  bit  hold_done = 1'b0;
  int  seg_left = 0;
  bit  seg_busy = 1'b0;
  int  stall_left = 0;

  vlan_timesync_frame_builder_top u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .vlan_id        (vlan_id),
    .link_id        (link_id),
    .source_mac     (source_mac),
    .message_type   (message_type),
    .first_time_ns  (first_time_ns),
    .second_time_ns (second_time_ns),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .frame_word     (frame_word),
    .last_word      (last_word)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Log and count one failure; the log is capped on a badly broken build.
  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 100) begin
      $display("ERROR at cycle %0d: %s", cycle_count, msg);
    end
  endtask

  // Build the whole frame for one request and queue its words in order.
  function automatic void predict_frame_words(input frame_desc_t d);
    logic [7:0]  fb [BUF_BYTES];
    logic [63:0] sec1;
    logic [63:0] rem1;
    logic [63:0] sec2;
    logic [63:0] rem2;
    frame_beat_t b;
    int i;
    for (i = 0; i < BUF_BYTES; i++) begin
      fb[i] = 8'h00;
    end
    fb[0] = DEST_FIRST;
    fb[4] = d.link[15:8];
    fb[5] = d.link[7:0];
    for (i = 0; i < 6; i++) begin
      fb[6 + i] = d.mac[8 * (5 - i) +: 8];
    end
    fb[12] = TPID_HI;
    fb[13] = TPID_LO;
    fb[14] = {4'h0, d.vlan[11:8]};
    fb[15] = d.vlan[7:0];
    fb[16] = ETYPE_HI;
    fb[17] = ETYPE_LO;
    fb[OFS_MSG] = d.mtype;
    for (i = 0; i < BLOB_LEN; i++) begin
      fb[OFS_BLOB + i] = BLOB_PATTERN[8 * (BLOB_LEN - 1 - i) +: 8];
    end
    // Seconds keep only their low 32 bits, so large stamps wrap.
    sec1 = d.t1 / ONE_SEC;
    rem1 = d.t1 % ONE_SEC;
    sec2 = d.t2 / ONE_SEC;
    rem2 = d.t2 % ONE_SEC;
    for (i = 0; i < 4; i++) begin
      fb[OFS_T1 + i]     = sec1[8 * (3 - i) +: 8];
      fb[OFS_T1 + 4 + i] = rem1[8 * (3 - i) +: 8];
      fb[OFS_T2 + i]     = sec2[8 * (3 - i) +: 8];
      fb[OFS_T2 + 4 + i] = rem2[8 * (3 - i) +: 8];
    end
    for (i = FRAME_BYTES; i < BUF_BYTES; i++) begin
      fb[i] = 8'h00;
    end
    for (i = 0; i < WORD_COUNT; i++) begin
      b.word = {fb[4 * i], fb[4 * i + 1], fb[4 * i + 2], fb[4 * i + 3]};
      b.last = (i == WORD_COUNT - 1);
      frame_words_due.push_back(b);
    end
  endfunction

  // Idle stretch length: mostly short, now and then long.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return $urandom_range(1, 3);
    end else if (r < 95) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 80);
  endfunction

  function automatic int sender_gap();
    if ($urandom_range(0, 99) < 55) begin
      return 0;
    end
    return idle_len();
  endfunction

  // Timestamps: full range, small, near a second boundary, past the wrap, near max, shifted.
  function automatic logic [63:0] random_time();
    logic [63:0] t;
    logic [63:0] k;
    case ($urandom_range(0, 5))
      0: t = {$urandom, $urandom};
      1: t = 64'($urandom);
      2, 3: begin
        if ($urandom_range(0, 1) == 0) begin
          k = 64'($urandom);
        end else begin
          k = {30'd0, 2'($urandom_range(1, 3)), $urandom};
        end
        t = k * ONE_SEC;
        case ($urandom_range(0, 2))
          0: t = t - 64'd1;
          1: t = t + 64'd1;
          default: t = t;
        endcase
      end
      4: t = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 1000));
      default: t = {$urandom, $urandom} >> $urandom_range(0, 63);
    endcase
    return t;
  endfunction

  function automatic logic [7:0] random_mtype();
    if ($urandom_range(0, 99) < 70) begin
      case ($urandom_range(0, 2))
        0: return MSG_SYNC;
        1: return MSG_REQUEST;
        default: return MSG_RESPONSE;
      endcase
    end
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic add_frame(input logic [11:0] vlan, input logic [15:0] link,
                           input logic [47:0] mac, input logic [7:0] mtype,
                           input logic [63:0] t1, input logic [63:0] t2,
                           input int gap, input bit drain_first);
    frame_desc_t d;
    d.vlan = vlan;
    d.link = link;
    d.mac = mac;
    d.mtype = mtype;
    d.t1 = t1;
    d.t2 = t2;
    d.gap = gap;
    d.drain_first = drain_first;
    pending_frames.push_back(d);
  endtask

  // Sender: present the next frame request whenever the current beat is taken.
  always @(negedge clk) begin
    if (!rst && (!in_valid || beats_in == offered)) begin
      if (pending_frames.size() == 0) begin
        in_valid <= 1'b0;
      end else if (pending_frames[0].gap > 0) begin
        pending_frames[0].gap = pending_frames[0].gap - 1;
        in_valid <= 1'b0;
      end else if (pending_frames[0].drain_first && frame_words_due.size() != 0) begin
        in_valid <= 1'b0;
      end else begin
        next_frame = pending_frames.pop_front();
        vlan_id <= next_frame.vlan;
        link_id <= next_frame.link;
        source_mac <= next_frame.mac;
        message_type <= next_frame.mtype;
        first_time_ns <= next_frame.t1;
        second_time_ns <= next_frame.t2;
        in_valid <= 1'b1;
        offered <= offered + 1;
      end
    end
  end

  // Receiver: one long hold early on, then calm and busy stretches.
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (!hold_done && beats_in >= HOLD_AFTER_BEATS) begin
        out_stall <= 1'b1;
        hold_left <= LONG_HOLD - 1;
        hold_done <= 1'b1;
      end else begin
        if (seg_left == 0) begin
          seg_left <= $urandom_range(50, 300);
          seg_busy <= ($urandom_range(0, 3) != 0);
        end else begin
          seg_left <= seg_left - 1;
        end
        if (stall_left > 0) begin
          out_stall <= 1'b1;
          stall_left <= stall_left - 1;
        end else if (seg_busy && $urandom_range(0, 99) < 30) begin
          out_stall <= 1'b1;
          stall_left <= idle_len() - 1;
        end else begin
          out_stall <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each output beat, then predict for each accepted input beat.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (frame_words_due.size() == 0) begin
          report_mismatch($sformatf("unexpected word %h last %b", frame_word, last_word));
        end else begin
          want_beat = frame_words_due.pop_front();
          if (frame_word !== want_beat.word) begin
            report_mismatch($sformatf("frame_word at word %0d: got %h, expected %h",
                                      words_seen, frame_word, want_beat.word));
          end
          if (last_word !== want_beat.last) begin
            report_mismatch($sformatf("last_word at word %0d: got %b, expected %b",
                                      words_seen, last_word, want_beat.last));
          end
          words_seen <= (want_beat.last) ? 0 : words_seen + 1;
        end
      end
      if (in_valid && !in_stall) begin
        taken_frame.vlan = vlan_id;
        taken_frame.link = link_id;
        taken_frame.mac = source_mac;
        taken_frame.mtype = message_type;
        taken_frame.t1 = first_time_ns;
        taken_frame.t2 = second_time_ns;
        taken_frame.gap = 0;
        taken_frame.drain_first = 1'b0;
        predict_frame_words(taken_frame);
        beats_in <= beats_in + 1;
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    // Directed frames: field extremes, each message type, second boundaries and wrap.
    add_frame(12'h000, 16'h0000, 48'h0, MSG_SYNC, 64'd0, 64'd0, 0, 1'b0);
    add_frame(12'hFFF, 16'hFFFF, 48'hFFFF_FFFF_FFFF, 8'hFF,
              64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 0, 1'b0);
    add_frame(12'h123, 16'h4567, 48'h0011_2233_4455, MSG_REQUEST,
              ONE_SEC - 64'd1, ONE_SEC, 0, 1'b0);
    add_frame(12'h321, 16'h7654, 48'h5544_3322_1100, MSG_RESPONSE,
              ONE_SEC, ONE_SEC + 64'd1, 0, 1'b0);
    add_frame(12'h0AB, 16'hCDEF, 48'h0203_0405_0607, MSG_SYNC,
              WRAP_NS, WRAP_NS - 64'd1, 0, 1'b0);
    add_frame(12'hAAA, 16'h5555, 48'hAAAA_AAAA_AAAA, 8'h55,
              64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 0, 1'b0);
    add_frame(12'h555, 16'hAAAA, 48'h5555_5555_5555, 8'hAA,
              64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 0, 1'b0);
    add_frame(12'h800, 16'h8000, 48'h8000_0000_0000, 8'h80,
              64'd1, 64'h8000_0000_0000_0000, 0, 1'b0);
    add_frame(12'h001, 16'h0001, 48'h0000_0000_0001, MSG_REQUEST,
              ONE_SEC - 64'd1, 64'd0, 0, 1'b1);
    add_frame(12'h7FF, 16'h7FFF, 48'h7FFF_FFFF_FFFF, 8'h7F,
              WRAP_NS - ONE_SEC + (ONE_SEC - 64'd1), WRAP_NS + ONE_SEC, 0, 1'b0);
    for (int n = 0; n < 10; n++) begin
      add_frame(12'($urandom), 16'($urandom), {16'($urandom), $urandom}, random_mtype(),
                random_time(), random_time(), 0, 1'b0);
    end

    // Random frames; one window goes back to back, two spots wait for a full drain.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      add_frame(12'($urandom), 16'($urandom), {16'($urandom), $urandom}, random_mtype(),
                random_time(), random_time(),
                (n >= 100 && n < 160) ? 0 : sender_gap(),
                (n == 250 || n == 400));
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Wait for the last request to be taken and its frame to come out.
    while (pending_frames.size() != 0 || (in_valid && beats_in != offered)) begin
      @(posedge clk);
    end
    while (frame_words_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_WAIT) @(posedge clk);
    if (frame_words_due.size() != 0) begin
      report_mismatch($sformatf("%0d expected words never arrived", frame_words_due.size()));
    end

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
